### rtl/deq_pkg.sv
package deq_pkg;

    // Default sizing of the ring storage.
    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    // Field widths on the stream ports.
    localparam int OP_W      = 3;
    localparam int ENTRY_W   = 32;
    localparam int INDEX_W   = 4;
    localparam int VALUE_W   = 32;
    localparam int LEN_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [OP_W-1:0] OP_PEEK_INDEX = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;          // capture a new request
        logic rd_en;          // read the ring entry the request addresses
        logic commit_direct;  // finish a request that needs no stored word
        logic commit_read;    // finish a request with the word just read
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;      // the held request returns a stored element
        logic out_free;       // the result register can take a new result
    } t_status;

endpackage

### rtl/double_ended_queue_core.sv
// Bounded double-ended queue of DEPTH words kept in a ring memory with a front
// pointer and an element count. Each request on the slave stream pushes or pops
// at either end, peeks at either end, or peeks at a position counted from the
// front; it returns exactly one result with the value, a found flag, the length
// after the request and a status (ok, empty, full). A request that returns a
// stored element passes through capture, a registered read of the ring memory
// and a result load in the controller; every other request skips the read
// (capture, result load). A new request is accepted only once the held one has
// finished, so the registered read port of the ring memory makes the requests
// that return an element the slower ones. A finished result waits in an output
// register, so the next request is captured while it is still pending; that
// request then holds in the controller until the receiver takes the waiting result.
// Stored words keep DATA_W bits; the reported length is the count modulo 32.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // op[2:0], entry[34:3], index[38:35]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // value[31:0], found[32], length[37:33],
                                            // status[39:38]
);

    t_cmd                cmd;
    t_status             status;
    logic [VALUE_W-1:0]  value;
    logic                found;
    logic [LEN_W-1:0]    length;
    logic [STATUS_W-1:0] result;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    deq_datapath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_op      (s_tdata[OP_W-1:0]),
        .i_entry   (s_tdata[OP_W+ENTRY_W-1:OP_W]),
        .i_index   (s_tdata[OP_W+ENTRY_W+INDEX_W-1:OP_W+ENTRY_W]),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_value   (value),
        .o_found   (found),
        .o_length  (length),
        .o_result  (result)
    );

    // Pack the result fields, value in the lowest bits.
    assign m_tdata = {result, length, found, value};

endmodule

### rtl/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign s_tready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.need_read) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_LOAD;
                end else if (i_status.out_free) begin
                    o_cmd.commit_direct = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.commit_read = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/deq_datapath.sv
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ENTRY_W-1:0]  i_entry,
    input  logic [INDEX_W-1:0]  i_index,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [VALUE_W-1:0]  o_value,
    output logic                o_found,
    output logic [LEN_W-1:0]    o_length,
    output logic [STATUS_W-1:0] o_result
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IXW = CW + INDEX_W;

    // Held request.
    logic [OP_W-1:0]    r_op;
    logic [ENTRY_W-1:0] r_entry;
    logic [INDEX_W-1:0] r_index;

    // Ring state and storage.
    logic [AW-1:0]     r_front;
    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Result register.
    logic                r_m_valid;
    logic [VALUE_W-1:0]  r_value;
    logic                r_found;
    logic [LEN_W-1:0]    r_length;
    logic [STATUS_W-1:0] r_result;

    logic                is_push;
    logic                hit;
    logic                full;
    logic                empty;
    logic [CW-1:0]       cnt_m1;
    logic [AW-1:0]       front_dec;
    logic [AW-1:0]       front_inc;
    logic [AW-1:0]       back_pos;
    logic [AW-1:0]       last_pos;
    logic [AW-1:0]       index_pos;
    logic [AW-1:0]       rd_pos;
    logic [AW-1:0]       wr_pos;
    logic                wr_en;
    logic [STATUS_W-1:0] direct_status;
    logic [AW-1:0]       n_front;
    logic [CW-1:0]       n_count;

    // Modular add of an offset below DEPTH to a ring position.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Ring positions for both ends and for an indexed peek.
    always_comb begin
        empty     = (r_count == '0);
        full      = (r_count >= CW'(DEPTH));
        cnt_m1    = r_count - 1'b1;
        front_dec = (r_front == '0) ? AW'(DEPTH - 1) : (r_front - 1'b1);
        front_inc = ring_add(r_front, AW'(1));
        back_pos  = ring_add(r_front, r_count[AW-1:0]);
        last_pos  = ring_add(r_front, cnt_m1[AW-1:0]);
        index_pos = ring_add(r_front, AW'(r_index));
    end

    // Request decode: which element is addressed and whether it exists.
    always_comb begin
        is_push       = 1'b0;
        hit           = 1'b0;
        rd_pos        = r_front;
        direct_status = ST_OK;
        unique case (r_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                is_push       = 1'b1;
                direct_status = full ? ST_FULL : ST_OK;
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                hit           = !empty;
                rd_pos        = r_front;
                direct_status = ST_EMPTY;
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                hit           = !empty;
                rd_pos        = last_pos;
                direct_status = ST_EMPTY;
            end
            OP_PEEK_INDEX: begin
                hit           = (IXW'(r_index) < IXW'(r_count));
                rd_pos        = index_pos;
                direct_status = ST_EMPTY;
            end
            default: begin
                direct_status = ST_OK;
            end
        endcase
    end

    // Pointer and count updates at the end of a request.
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_pos  = back_pos;
        if (i_cmd.commit_direct && is_push && !full) begin
            wr_en   = 1'b1;
            n_count = r_count + 1'b1;
            if (r_op == OP_PUSH_FRONT) begin
                n_front = front_dec;
                wr_pos  = front_dec;
            end
        end
        if (i_cmd.commit_read) begin
            if (r_op == OP_POP_FRONT) begin
                n_front = front_inc;
                n_count = cnt_m1;
            end else if (r_op == OP_POP_BACK) begin
                n_count = cnt_m1;
            end
        end
    end

    assign o_status.need_read = hit;
    assign o_status.out_free  = !r_m_valid || i_m_ready;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_op;
            r_entry <= i_entry;
            r_index <= i_index;
        end
    end

    // Ring storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_pos] <= DATA_W'(r_entry);
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_pos];
        end
    end

    // Ring pointer and element count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.commit_direct || i_cmd.commit_read) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_direct) begin
            r_value  <= '0;
            r_found  <= 1'b0;
            r_length <= LEN_W'(n_count);
            r_result <= direct_status;
        end else if (i_cmd.commit_read) begin
            r_value  <= VALUE_W'(r_rdata);
            r_found  <= 1'b1;
            r_length <= LEN_W'(n_count);
            r_result <= ST_OK;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_value   = r_value;
    assign o_found   = r_found;
    assign o_length  = r_length;
    assign o_result  = r_result;

endmodule
